### sv/dtd_pkg.sv
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types and constants of the depth temporal delta stage.
// ----------------------------------------------------------------------------
package dtd_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int SIZE_W     = $clog2(MAX_PIXELS + 1);

  localparam int DEPTH_W    = 15;
  localparam int ZCNT_W     = 8;
  localparam int DIFF_W     = 16;
  localparam int OFFSET_W   = 15;
  localparam int FRAME_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = FRAME_W'(524288);
  localparam logic [DEPTH_W-1:0] CHANGE_THR_RST   = '0;
  localparam logic [ZCNT_W-1:0]  INVALID_THR_RST  = ZCNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_PIXELS = 2'd0,
    CFG_CHANGE_THR   = 2'd1,
    CFG_INVALID_THR  = 2'd2
  } cfg_reg_e;

  // One frame store entry: held depth and zero-run count.
  typedef struct packed {
    logic [DEPTH_W-1:0] held;
    logic [ZCNT_W-1:0]  zcnt;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } store_wr_t;

endpackage

### sv/dtd_store.sv
// ----------------------------------------------------------------------------
// dtd_store
// Per-pixel frame store: one synchronous memory, one read and one write per
// cycle, a fill mark standing in for the cleared reset contents, and a bypass
// for a read that lands on the entry written at the same edge.
// ----------------------------------------------------------------------------
module dtd_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [dtd_pkg::IDX_W-1:0]     rd_idx_i,
  input  dtd_pkg::store_wr_t            wr_i,
  output dtd_pkg::entry_t               rd_entry_o
);

  dtd_pkg::entry_t mem [dtd_pkg::MAX_PIXELS];

  dtd_pkg::entry_t                rdata_q;
  dtd_pkg::entry_t                fwd_entry_q;
  logic                           fwd_q;
  logic                           rd_ok_q;
  logic [dtd_pkg::SIZE_W-1:0]     fill_q;
  logic [dtd_pkg::SIZE_W-1:0]     fill_d;
  logic                           rd_ok_d;
  logic                           fwd_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rdata_q     <= mem[rd_idx_i];
      fwd_entry_q <= wr_i.entry;
    end
  end

  // Entries are visited in order from zero, so everything below the fill
  // mark has been written and everything at or above it still reads zero.
  always_comb begin
    fill_d = fill_q;
    if (wr_i.en && (dtd_pkg::SIZE_W'(wr_i.idx) == fill_q)) begin
      fill_d = fill_q + dtd_pkg::SIZE_W'(1);
    end
    rd_ok_d = dtd_pkg::SIZE_W'(rd_idx_i) < fill_q;
    fwd_d   = wr_i.en && (wr_i.idx == rd_idx_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fwd_q   <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        fwd_q   <= fwd_d;
        rd_ok_q <= rd_ok_d;
      end
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_entry_o = fwd_entry_q;
    end else if (rd_ok_q) begin
      rd_entry_o = rdata_q;
    end else begin
      rd_entry_o = '0;
    end
  end

endmodule

### sv/dtd_update.sv
// ----------------------------------------------------------------------------
// dtd_update
// Per-pixel update rule: new held depth, new zero-run count and the signed
// difference for one pixel.
// ----------------------------------------------------------------------------
module dtd_update (
  input  logic [dtd_pkg::DEPTH_W-1:0]   depth_i,
  input  logic                          key_i,
  input  dtd_pkg::entry_t               old_i,
  input  logic [dtd_pkg::DEPTH_W-1:0]   change_thr_i,
  input  logic [dtd_pkg::ZCNT_W-1:0]    invalid_thr_i,
  output dtd_pkg::entry_t               new_o,
  output logic signed [dtd_pkg::DIFF_W-1:0] diff_o
);

  logic [dtd_pkg::ZCNT_W-1:0]  cnt_inc;
  logic [dtd_pkg::DEPTH_W-1:0] abs_delta;

  always_comb begin
    cnt_inc   = (old_i.zcnt == '1) ? old_i.zcnt : old_i.zcnt + dtd_pkg::ZCNT_W'(1);
    abs_delta = (old_i.held > depth_i) ? old_i.held - depth_i : depth_i - old_i.held;

    new_o  = old_i;
    diff_o = '0;
    priority if (key_i) begin
      new_o.held = depth_i;
      new_o.zcnt = dtd_pkg::ZCNT_W'(depth_i == '0);
      diff_o     = $signed({1'b0, depth_i});
    end else begin
      priority if (old_i.held == '0) begin
        // empty pixel takes any valid depth
        if (depth_i != '0) begin
          new_o.held = depth_i;
        end
      end else if (depth_i == '0) begin
        new_o.zcnt = cnt_inc;
        if (cnt_inc >= invalid_thr_i) begin
          new_o.held = '0;
          new_o.zcnt = '0;
        end
      end else begin
        new_o.zcnt = '0;
        if (abs_delta > change_thr_i) begin
          new_o.held = depth_i;
        end
      end
      diff_o = $signed({1'b0, new_o.held}) - $signed({1'b0, old_i.held});
    end
  end

endmodule

### sv/depth_temporal_delta_stage.sv
// ----------------------------------------------------------------------------
// depth_temporal_delta_stage
// Temporal delta coder for a raster depth stream with a per-pixel frame store.
// ----------------------------------------------------------------------------
// Takes one depth pixel per cycle, sustained, with no gaps between beats and
// no gaps between frames. Once an input beat is taken, the frame store read
// for its pixel is registered; then the update rule is applied, the entry is
// written back and the result is loaded into the output register. The
// store is one memory with a read port and a write port, so it carries one
// pixel per cycle; a read of the entry written in the same cycle (frame of
// one pixel) is bypassed. The store is ready right after reset with no
// clearing pass: entries not yet visited since reset read as zero. The input
// is held off only while a result waits on a stalled output.
module depth_temporal_delta_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dtd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dtd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dtd_pkg::DEPTH_W-1:0]       depth_in_i,
  input  logic                              key_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dtd_pkg::DIFF_W-1:0] pixel_diff_o,
  output logic [dtd_pkg::OFFSET_W-1:0]      frame_offset_o,
  output logic                              last_pixel_o
);

  // configuration
  logic [dtd_pkg::FRAME_W-1:0] frame_pixels_q;
  logic [dtd_pkg::DEPTH_W-1:0] change_thr_q;
  logic [dtd_pkg::ZCNT_W-1:0]  invalid_thr_q;

  // frame position
  logic [dtd_pkg::IDX_W-1:0]   pixel_idx_q;
  logic [dtd_pkg::IDX_W-1:0]   pixel_idx_d;
  logic [dtd_pkg::SIZE_W-1:0]  frame_size;
  logic                        in_last;

  // update stage
  logic                        s1_valid_q;
  logic [dtd_pkg::IDX_W-1:0]   s1_idx_q;
  logic [dtd_pkg::DEPTH_W-1:0] s1_depth_q;
  logic                        s1_key_q;
  logic                        s1_last_q;
  logic                        s1_first_q;

  logic signed [dtd_pkg::DIFF_W-1:0] min_diff_q;
  logic signed [dtd_pkg::DIFF_W-1:0] min_diff_d;
  logic signed [dtd_pkg::DIFF_W-1:0] min_base;
  logic signed [dtd_pkg::DIFF_W-1:0] neg_min;
  logic signed [dtd_pkg::DIFF_W-1:0] diff;
  logic [dtd_pkg::OFFSET_W-1:0]      offset_d;

  logic                        out_adv;
  logic                        s1_adv;
  logic                        in_accept;

  dtd_pkg::entry_t             old_entry;
  dtd_pkg::entry_t             new_entry;
  dtd_pkg::store_wr_t          store_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pixels_q <= dtd_pkg::FRAME_PIXELS_RST;
      change_thr_q   <= dtd_pkg::CHANGE_THR_RST;
      invalid_thr_q  <= dtd_pkg::INVALID_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dtd_pkg::CFG_FRAME_PIXELS: frame_pixels_q <= cfg_wdata_i[dtd_pkg::FRAME_W-1:0];
        dtd_pkg::CFG_CHANGE_THR:   change_thr_q   <= cfg_wdata_i[dtd_pkg::DEPTH_W-1:0];
        dtd_pkg::CFG_INVALID_THR:  invalid_thr_q  <= cfg_wdata_i[dtd_pkg::ZCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_adv    = !out_valid_o || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Out-of-range frame sizes act as the full store.
  always_comb begin
    if ((frame_pixels_q == '0) || (32'(frame_pixels_q) > 32'(dtd_pkg::MAX_PIXELS))) begin
      frame_size = dtd_pkg::SIZE_W'(dtd_pkg::MAX_PIXELS);
    end else begin
      frame_size = dtd_pkg::SIZE_W'(frame_pixels_q);
    end
    in_last     = (dtd_pkg::SIZE_W'(pixel_idx_q) + dtd_pkg::SIZE_W'(1)) >= frame_size;
    pixel_idx_d = in_last ? '0 : pixel_idx_q + dtd_pkg::IDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_idx_q <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        pixel_idx_q <= pixel_idx_d;
        s1_valid_q  <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_idx_q   <= pixel_idx_q;
      s1_depth_q <= depth_in_i;
      s1_key_q   <= key_frame_i;
      s1_last_q  <= in_last;
      s1_first_q <= (pixel_idx_q == '0);
    end
  end

  assign store_wr.en    = s1_adv;
  assign store_wr.idx   = s1_idx_q;
  assign store_wr.entry = new_entry;

  dtd_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_idx_i   (pixel_idx_q),
    .wr_i       (store_wr),
    .rd_entry_o (old_entry)
  );

  dtd_update u_update (
    .depth_i       (s1_depth_q),
    .key_i         (s1_key_q),
    .old_i         (old_entry),
    .change_thr_i  (change_thr_q),
    .invalid_thr_i (invalid_thr_q),
    .new_o         (new_entry),
    .diff_o        (diff)
  );

  // Restart the running minimum on the first pixel of a frame; key pixels
  // leave it alone.
  always_comb begin
    min_base   = s1_first_q ? '0 : min_diff_q;
    min_diff_d = (!s1_key_q && (diff < min_base)) ? diff : min_base;
    neg_min    = -min_diff_d;
    offset_d   = (s1_last_q && !s1_key_q) ? neg_min[dtd_pkg::OFFSET_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_diff_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_adv) begin
        min_diff_q <= min_diff_d;
      end
      if (out_adv) begin
        out_valid_o <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_diff_o   <= diff;
      frame_offset_o <= offset_d;
      last_pixel_o   <= s1_last_q;
    end
  end

endmodule

### sv/dtd_checker.sv
// ----------------------------------------------------------------------------
// dtd_checker
// Port-level checks for the depth temporal delta stage.
// ----------------------------------------------------------------------------
module dtd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic signed [dtd_pkg::DIFF_W-1:0] pixel_diff_o,
  input  logic [dtd_pkg::OFFSET_W-1:0]      frame_offset_o,
  input  logic                              last_pixel_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_diff_o)
      && $stable(frame_offset_o) && $stable(last_pixel_o))
    else $error("stalled result changed");

  // input is held off only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a taken beat reaches the output through the update stage when the output is not stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after accepted beat");

  // offset only on the closing pixel of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pixel_o |-> frame_offset_o == '0)
    else $error("frame offset outside last pixel");

  // difference never reaches the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_diff_o != 16'sh8000)
    else $error("pixel difference out of range");

endmodule

bind depth_temporal_delta_stage dtd_checker u_dtd_checker (.*);

### dv/tb_depth_temporal_delta_stage.sv
// ----------------------------------------------------------------------------
// tb_depth_temporal_delta_stage
// Self-checking bench for the depth temporal delta stage. A short directed
// table (extremes, key and delta pixels, frame size changes, threshold
// corners) runs first. Random frames follow with mixed key, dropout and live
// content under many register settings. Every result beat is checked against
// a typed-in result or a predictor holding its own copy of the frame store.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_depth_temporal_delta_stage;
  import dtd_pkg::*;

  localparam int N_PHASE     = 14;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_PHASE  = 3;
  localparam int CALM_PHASE  = 6;
  localparam int DRAIN_PHASE = 9;
  localparam int RX_HOLD     = 200;
  localparam int WDOG_LIMIT  = 3000;
  localparam int DEPTH_MAX   = 32767;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [OFFSET_W-1:0]      off;
    logic                     last;
  } px_res_t;

  typedef enum bit {ROW_PIXEL, ROW_WRITE} row_kind_e;
  typedef enum bit [1:0] {MODE_KEY, MODE_DROP, MODE_LIVE} gen_mode_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  cidx;
    logic [CFG_DATA_W-1:0] cval;
    logic [DEPTH_W-1:0]    depth;
    bit                    key;
    bit                    typed;
    px_res_t               res;
  } dir_row_t;

  localparam int N_DIR = 31;

  // Expected results are typed in where they follow directly from the rules;
  // the remaining rows go through the predictor.
  dir_row_t dir_tab [N_DIR] = '{
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd32767, 1'b1, 1'b1, '{16'sd32767, 15'd0, 1'b0}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b1, 1'b1, '{16'sd0, 15'd0, 1'b0}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd5, 1'b0, 1'b1, '{16'sd5, 15'd0, 1'b0}},
    // shrink the frame below the current pixel: next pixel closes it
    '{ROW_WRITE, CFG_FRAME_PIXELS, 20'd2, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd1, 1'b0, 1'b1, '{16'sd1, 15'd0, 1'b1}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b1, '{16'sd0, 15'd0, 1'b0}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd1, 1'b0, 1'b1, '{16'sd1, 15'd0, 1'b1}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b1, '{-16'sd32767, 15'd0, 1'b0}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b1, '{-16'sd1, 15'd32767, 1'b1}},
    '{ROW_WRITE, CFG_FRAME_PIXELS, 20'd1, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd100, 1'b1, 1'b1, '{16'sd100, 15'd0, 1'b1}},
    '{ROW_WRITE, CFG_CHANGE_THR, 20'd32767, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd32767, 1'b0, 1'b1, '{16'sd0, 15'd0, 1'b1}},
    '{ROW_WRITE, CFG_CHANGE_THR, 20'd0, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd101, 1'b0, 1'b1, '{16'sd1, 15'd0, 1'b1}},
    // zero threshold: any zero clears a held pixel
    '{ROW_WRITE, CFG_INVALID_THR, 20'd0, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b1, '{-16'sd101, 15'd101, 1'b1}},
    '{ROW_WRITE, CFG_INVALID_THR, 20'd1, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd7, 1'b1, 1'b1, '{16'sd7, 15'd0, 1'b1}},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b1, '{-16'sd7, 15'd7, 1'b1}},
    // out of range frame sizes act as the full store
    '{ROW_WRITE, CFG_FRAME_PIXELS, 20'hFFFFF, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd32767, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd16384, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b1, 1'b0, '0},
    '{ROW_WRITE, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd12345, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_SPARE, 20'hAAAAA, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_FRAME_PIXELS, 20'd3, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_PIXEL, CFG_FRAME_PIXELS, 20'd0, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_INVALID_THR, 20'd255, 15'd0, 1'b0, 1'b0, '0},
    '{ROW_WRITE, CFG_CHANGE_THR, 20'h55555, 15'd0, 1'b0, 1'b0, '0}
  };

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [DEPTH_W-1:0]       depth_in_i = '0;
  logic                     key_frame_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DIFF_W-1:0] pixel_diff_o;
  logic [OFFSET_W-1:0]      frame_offset_o;
  logic                     last_pixel_o;

  depth_temporal_delta_stage dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .depth_in_i     (depth_in_i),
    .key_frame_i    (key_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_diff_o   (pixel_diff_o),
    .frame_offset_o (frame_offset_o),
    .last_pixel_o   (last_pixel_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Predictor state: frame store copy, frame position and register mirror.
  bit [DEPTH_W-1:0]   held_mem [MAX_PIXELS];
  bit [ZCNT_W-1:0]    zrun_mem [MAX_PIXELS];
  int unsigned        px_idx = 0;
  int                 min_seen = 0;
  logic [FRAME_W-1:0] frame_reg = FRAME_PIXELS_RST;
  logic [DEPTH_W-1:0] chg_thr_reg = CHANGE_THR_RST;
  logic [ZCNT_W-1:0]  inv_thr_reg = INVALID_THR_RST;

  px_res_t pend_px [$];
  int      n_bad = 0;
  int      n_px = 0;
  int      n_res = 0;
  int      n_frame_end = 0;
  int      n_offset = 0;
  int      n_writes = 0;
  int      stuck_cycles = 0;
  bit      calm = 1'b0;
  bit      rx_hold_req = 1'b0;

  task automatic predict_pixel(input int d, input bit k, output px_res_t r);
    int unsigned size;
    int unsigned ix;
    int unsigned old_v;
    int unsigned cur_v;
    int unsigned c;
    int unsigned ad;
    int          delta;
    bit          is_last;
    size = (frame_reg == 0 || frame_reg > MAX_PIXELS) ? MAX_PIXELS : frame_reg;
    ix = (px_idx >= MAX_PIXELS) ? MAX_PIXELS - 1 : px_idx;
    if (px_idx == 0) min_seen = 0;
    if (k) begin
      held_mem[ix] = DEPTH_W'(d);
      zrun_mem[ix] = (d == 0) ? ZCNT_W'(1) : '0;
      delta = d;
    end else begin
      old_v = held_mem[ix];
      cur_v = old_v;
      if (old_v == 0) begin
        if (d != 0) cur_v = d;
      end else if (d == 0) begin
        c = zrun_mem[ix];
        if (c < 255) c++;
        if (c >= inv_thr_reg) begin
          cur_v = 0;
          c = 0;
        end
        zrun_mem[ix] = ZCNT_W'(c);
      end else begin
        ad = (old_v > d) ? old_v - d : d - old_v;
        zrun_mem[ix] = '0;
        if (ad > chg_thr_reg) cur_v = d;
      end
      held_mem[ix] = DEPTH_W'(cur_v);
      delta = int'(cur_v) - int'(old_v);
      if (delta < min_seen) min_seen = delta;
    end
    is_last = (px_idx + 1 >= size);
    r.diff = DIFF_W'(delta);
    r.last = is_last;
    r.off = '0;
    if (is_last) begin
      if (!k) r.off = OFFSET_W'(-min_seen);
      px_idx = 0;
    end else begin
      px_idx++;
    end
  endtask

  // Offer one beat, wait for it to be taken, then record what it should give.
  task automatic push_pixel(input int d, input bit k, input bit typed, input px_res_t tres);
    px_res_t pr;
    in_valid_i  <= 1'b1;
    depth_in_i  <= DEPTH_W'(d);
    key_frame_i <= k;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_pixel(d, k, pr);
    pend_px.push_back(typed ? tres : pr);
    n_px++;
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every pending result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend_px.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FRAME_PIXELS: frame_reg = val[FRAME_W-1:0];
      CFG_CHANGE_THR:   chg_thr_reg = val[DEPTH_W-1:0];
      CFG_INVALID_THR:  inv_thr_reg = val[ZCNT_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  function automatic gen_mode_e pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 20) return MODE_KEY;
    if (r < 45) return MODE_DROP;
    return MODE_LIVE;
  endfunction

  // Depth near the held value, just inside or outside the change threshold.
  function automatic int near_depth();
    int h;
    int delta;
    int v;
    h = held_mem[px_idx];
    if (h == 0) return $urandom_range(1, DEPTH_MAX);
    delta = int'(chg_thr_reg) + int'($urandom_range(0, 6)) - 3;
    v = $urandom_range(1) ? h + delta : h - delta;
    if (v < 1) v = 1;
    if (v > DEPTH_MAX) v = DEPTH_MAX;
    return v;
  endfunction

  function automatic int pick_depth(gen_mode_e m);
    int r;
    r = $urandom_range(99);
    case (m)
      MODE_KEY:  return (r < 15) ? 0 : $urandom_range(0, DEPTH_MAX);
      MODE_DROP: return (r < 85) ? 0 : near_depth();
      default: begin
        if (r < 12) return 0;
        if (r < 20) return $urandom_range(0, DEPTH_MAX);
        if (r < 24) return DEPTH_MAX;
        if (r < 27) return 1;
        return near_depth();
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_frame();
    case ($urandom_range(9))
      0: return CFG_DATA_W'(1);
      1: return $urandom_range(1) ? '0 : CFG_DATA_W'($urandom_range(MAX_PIXELS + 1, 20'hFFFFF));
      default: return CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_change_thr();
    case ($urandom_range(4))
      0: return '0;
      1: return CFG_DATA_W'(DEPTH_MAX);
      2: return CFG_DATA_W'($urandom_range(0, 40));
      3: return CFG_DATA_W'($urandom_range(0, 2000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_invalid_thr();
    case ($urandom_range(4))
      0: return '0;
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(2, 6));
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off on request, calm stretch.
  initial begin : rx_proc
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD) @(posedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 36);
      end
    end
  end

  // Result check and progress watchdog.
  always @(posedge clk_i) begin
    px_res_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WDOG_LIMIT) begin
        $display("%0t no beat moved for %0d cycles", $time, WDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else if (out_valid_o === 1'b1 && !out_stall_i) begin
        n_res++;
        if (pend_px.size() == 0) begin
          n_bad++;
          $display("%0t unexpected result: diff %0d offset %0d last %0b", $time,
                   pixel_diff_o, frame_offset_o, last_pixel_o);
        end else begin
          e = pend_px.pop_front();
          if (pixel_diff_o !== e.diff) begin
            n_bad++;
            $display("%0t pixel_diff mismatch: expected %0d, actual %0d", $time,
                     e.diff, pixel_diff_o);
          end
          if (frame_offset_o !== e.off) begin
            n_bad++;
            $display("%0t frame_offset mismatch: expected %0d, actual %0d", $time,
                     e.off, frame_offset_o);
          end
          if (last_pixel_o !== e.last) begin
            n_bad++;
            $display("%0t last_pixel mismatch: expected %0b, actual %0b", $time,
                     e.last, last_pixel_o);
          end
          if (e.last) n_frame_end++;
          if (e.off != 0) n_offset++;
        end
      end
    end
  end

  initial begin : stim
    gen_mode_e mode;
    int        d;
    bit        k;
    mode = MODE_LIVE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        settle();
        reg_write(dir_tab[i].cidx, dir_tab[i].cval);
      end else begin
        push_pixel(dir_tab[i].depth, dir_tab[i].key, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    for (int ph = 0; ph < N_PHASE; ph++) begin
      settle();
      reg_write(CFG_FRAME_PIXELS, pick_frame());
      reg_write(CFG_CHANGE_THR, pick_change_thr());
      reg_write(CFG_INVALID_THR, pick_invalid_thr());
      calm = (ph == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (px_idx == 0 || n == 0) mode = pick_mode();
        if (ph == HOLD_PHASE && n == 30) rx_hold_req = 1'b1;
        if (ph == DRAIN_PHASE && n == 50) settle();
        k = (mode == MODE_KEY);
        if ($urandom_range(19) == 0) k = !k;
        d = pick_depth(mode);
        push_pixel(d, k, 1'b0, '0);
      end
      calm = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d pixel beats, checked %0d results over %0d register writes",
             n_px, n_res, n_writes);
    $display("Saw %0d frame ends, %0d with a nonzero offset, %0d mismatches",
             n_frame_end, n_offset, n_bad);
    if (n_bad == 0 && pend_px.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/dtd_pkg.sv
sv/dtd_store.sv
sv/dtd_update.sv
sv/depth_temporal_delta_stage.sv
sv/dtd_checker.sv
dv/tb_depth_temporal_delta_stage.sv
